@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the n-step return accumulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define NSR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define NSR_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/nsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nsr_pkg
// Types, widths and register codes of the n-step return accumulator.
// ----------------------------------------------------------------------------
package nsr_pkg;

   localparam int ACTION_W   = 16;
   localparam int REWARD_W   = 32;
   localparam int SLOT_W     = 10;
   localparam int DISCOUNT_W = 17;
   localparam int WINDOW_W   = 4;
   localparam int TERM_W     = 34;
   localparam int POWER_MUL_W = 2 * DISCOUNT_W;

   localparam int MAX_WINDOW_DEFAULT = 8;
   localparam int RING_DEPTH_DEFAULT = 1024;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   localparam logic [DISCOUNT_W-1:0] DISCOUNT_RESET = 17'd64881;
   localparam logic [DISCOUNT_W-1:0] DISCOUNT_ONE   = 17'd65536;
   localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = 4'd3;

   localparam logic REG_DISCOUNT = 1'b0;
   localparam logic REG_WINDOW   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } nsr_state_type;

   typedef struct packed {
      logic                       mul_en;
      logic                       shift_en;
      logic signed [REWARD_W-1:0] reward;
   } nsr_cell_ctrl_type;

   typedef struct packed {
      logic [DISCOUNT_W-1:0] discount;
      logic [WINDOW_W-1:0]   window_len;
      logic                  discount_wr;
   } nsr_cfg_type;

endpackage

@@ rtl/nsr_req_if.sv @@
// ----------------------------------------------------------------------------
// nsr_req_if
// Input channel: one environment step per item.
// ----------------------------------------------------------------------------
interface nsr_req_if;
   import nsr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        step_action;
   logic signed [REWARD_W-1:0] step_reward;
   logic                       episode_end;

   modport source(output valid, step_action, step_reward, episode_end, input ready);
   modport sink(input valid, step_action, step_reward, episode_end, output ready);
endinterface

@@ rtl/nsr_rsp_if.sv @@
// ----------------------------------------------------------------------------
// nsr_rsp_if
// Result channel: one emitted discounted return per item.
// ----------------------------------------------------------------------------
interface nsr_rsp_if;
   import nsr_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        out_action;
   logic signed [REWARD_W-1:0] out_return;
   logic                       out_done;
   logic [SLOT_W-1:0]          slot;
   logic                       last_of_run;

   modport source(output valid, out_action, out_return, out_done, slot, last_of_run,
                  input ready);
   modport sink(input valid, out_action, out_return, out_done, slot, last_of_run,
                output ready);
endinterface

@@ rtl/nsr_csr.sv @@
// ----------------------------------------------------------------------------
// nsr_csr
// APB-style register block holding the discount factor and window length.
// ----------------------------------------------------------------------------
module nsr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [nsr_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [nsr_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [nsr_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output nsr_pkg::nsr_cfg_type          cfg
);
   import nsr_pkg::*;

   logic [DISCOUNT_W-1:0] discount_ff;
   logic [WINDOW_W-1:0]   window_ff;
   logic                  wr_en;
   logic                  reg_sel;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         discount_ff <= DISCOUNT_RESET;
         window_ff   <= WINDOW_RESET;
      end else if (wr_en) begin
         unique case (reg_sel)
            REG_DISCOUNT: discount_ff <= csr_pwdata[DISCOUNT_W-1:0];
            REG_WINDOW:   window_ff   <= csr_pwdata[WINDOW_W-1:0];
            default:      discount_ff <= discount_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DISCOUNT: csr_prdata = {{(CSR_DW-DISCOUNT_W){1'b0}}, discount_ff};
         REG_WINDOW:   csr_prdata = {{(CSR_DW-WINDOW_W){1'b0}}, window_ff};
         default:      csr_prdata = '0;
      endcase
   end

   assign cfg.discount    = (discount_ff > DISCOUNT_ONE) ? DISCOUNT_ONE : discount_ff;
   assign cfg.window_len  = window_ff;
   assign cfg.discount_wr = wr_en && (reg_sel == REG_DISCOUNT);

endmodule

@@ rtl/nsr_cell.sv @@
// ----------------------------------------------------------------------------
// nsr_cell
// One window entry: action, running return and its discount power.
// ----------------------------------------------------------------------------
module nsr_cell (
   input  logic                                clock,
   input  nsr_pkg::nsr_cell_ctrl_type          ctrl,
   input  logic [nsr_pkg::DISCOUNT_W-1:0]      discount,
   input  logic [nsr_pkg::DISCOUNT_W-1:0]      power_in,
   output logic [nsr_pkg::DISCOUNT_W-1:0]      power_out,
   input  logic [nsr_pkg::ACTION_W-1:0]        action_in,
   input  logic signed [nsr_pkg::REWARD_W-1:0] return_in,
   output logic [nsr_pkg::ACTION_W-1:0]        action_out,
   output logic signed [nsr_pkg::REWARD_W-1:0] return_out,
   output logic signed [nsr_pkg::REWARD_W-1:0] updated_out
);
   import nsr_pkg::*;

   localparam int PROD_W = REWARD_W + DISCOUNT_W + 1;
   localparam int SUM_W  = TERM_W + 1;
   localparam logic signed [SUM_W-1:0] SAT_MAX = 35'sd2147483647;
   localparam logic signed [SUM_W-1:0] SAT_MIN = -35'sd2147483648;

   logic [DISCOUNT_W-1:0]      power_ff;
   logic [DISCOUNT_W-1:0]      power_in_next;
   logic [POWER_MUL_W-1:0]     power_prod;
   logic [ACTION_W-1:0]        action_ff;
   logic signed [REWARD_W-1:0] return_ff;
   logic signed [TERM_W-1:0]   term_ff;
   logic signed [TERM_W-1:0]   term_in;
   logic signed [PROD_W-1:0]   reward_prod;
   logic signed [SUM_W-1:0]    sum;

   // The power of this entry's age follows from its neighbor's power.
   assign power_prod    = power_in * discount;
   assign power_in_next = power_prod[DISCOUNT_W+15:16];

   assign reward_prod = ctrl.reward * $signed({1'b0, power_ff});
   assign term_in     = reward_prod[PROD_W-1:16];

   assign sum = {{(SUM_W-REWARD_W){return_ff[REWARD_W-1]}}, return_ff}
              + {term_ff[TERM_W-1], term_ff};

   always_comb begin
      priority if (sum > SAT_MAX) begin
         updated_out = SAT_MAX[REWARD_W-1:0];
      end else if (sum < SAT_MIN) begin
         updated_out = SAT_MIN[REWARD_W-1:0];
      end else begin
         updated_out = sum[REWARD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      power_ff <= power_in_next;
      if (ctrl.mul_en) begin
         term_ff <= term_in;
      end
      if (ctrl.shift_en) begin
         action_ff <= action_in;
         return_ff <= return_in;
      end
   end

   assign power_out  = power_ff;
   assign action_out = action_ff;
   assign return_out = return_ff;

endmodule

@@ rtl/n_step_return_accumulator.sv @@
// An accepted item passes the multiply and add steps of the cell chain, then the emit
// state loads each result into the output register. An item that emits nothing lets a
// new item be accepted in its add step; one that emits results blocks new items until
// its run ends, and the output register takes one result per cycle while the result
// side is ready. Reset clears the window fill count and the ring slot; after reset and
// every discount write, no item is accepted while the power chain settles.
// ----------------------------------------------------------------------------
// n_step_return_accumulator
// Chain of window cells accumulating n-step discounted returns per step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module n_step_return_accumulator #(
   parameter int MAX_WINDOW = nsr_pkg::MAX_WINDOW_DEFAULT,
   parameter int RING_DEPTH = nsr_pkg::RING_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   nsr_req_if.sink                    req_ch,
   nsr_rsp_if.source                  rsp_ch,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [nsr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [nsr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [nsr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);
   import nsr_pkg::*;

   localparam int CW = $clog2(MAX_WINDOW + 1);
   localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LW = (CW > WINDOW_W) ? CW : WINDOW_W;
   localparam int RW = $clog2(RING_DEPTH);

   nsr_cfg_type       cfg;
   nsr_cell_ctrl_type ctrl;
   nsr_state_type     state_ff, state_in;

   logic [CW-1:0]              cnt_ff, cnt_in, cnt_p1, cnt_m1, cnt_base, cnt_trunc;
   logic [CW-1:0]              settle_ff, settle_in;
   logic [RW-1:0]              ws_ff, ws_in, ws_next;
   logic [LW-1:0]              win_ext, n_eff, n_m1;
   logic [IW-1:0]              emit_idx;
   logic [ACTION_W-1:0]        act_ff;
   logic signed [REWARD_W-1:0] rew_ff;
   logic                       done_ff;
   logic                       req_ready, accept, emit_go, last_w, load;
   logic                       rsp_valid_ff;
   logic [ACTION_W-1:0]        rsp_action_ff;
   logic signed [REWARD_W-1:0] rsp_return_ff;
   logic                       rsp_done_ff, rsp_last_ff;
   logic [SLOT_W-1:0]          rsp_slot_ff;
   logic [RW+SLOT_W-1:0]       ws_wide;

   logic [DISCOUNT_W-1:0]      power_chain [MAX_WINDOW+1];
   logic [ACTION_W-1:0]        act_chain   [MAX_WINDOW+1];
   logic signed [REWARD_W-1:0] upd_chain   [MAX_WINDOW+1];
   logic [ACTION_W-1:0]        act_arr     [MAX_WINDOW];
   logic signed [REWARD_W-1:0] ret_arr     [MAX_WINDOW];

   nsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign power_chain[0] = DISCOUNT_ONE;
   assign act_chain[0]   = act_ff;
   assign upd_chain[0]   = rew_ff;

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      nsr_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .discount    (cfg.discount),
         .power_in    (power_chain[k]),
         .power_out   (power_chain[k+1]),
         .action_in   (act_chain[k]),
         .return_in   (upd_chain[k]),
         .action_out  (act_arr[k]),
         .return_out  (ret_arr[k]),
         .updated_out (upd_chain[k+1])
      );
      assign act_chain[k+1] = act_arr[k];
   end

   assign win_ext = LW'(cfg.window_len);
   always_comb begin
      priority if (cfg.window_len == '0) begin
         n_eff = LW'(1);
      end else if (win_ext > LW'(MAX_WINDOW)) begin
         n_eff = LW'(MAX_WINDOW);
      end else begin
         n_eff = win_ext;
      end
   end
   assign n_m1 = n_eff - 1'b1;

   assign cnt_p1    = cnt_ff + 1'b1;
   assign cnt_m1    = cnt_ff - 1'b1;
   assign emit_idx  = cnt_m1[IW-1:0];
   assign cnt_base  = (state_ff == ST_ADD) ? cnt_p1 : cnt_ff;
   assign cnt_trunc = (LW'(cnt_base) > n_m1) ? n_m1[CW-1:0] : cnt_base;
   assign emit_go   = done_ff || (LW'(cnt_p1) >= n_eff);
   assign last_w    = !done_ff || (cnt_ff == CW'(1));
   assign ws_next   = (ws_ff == RW'(RING_DEPTH - 1)) ? '0 : ws_ff + 1'b1;
   assign ws_wide   = {{SLOT_W{1'b0}}, ws_ff};

   assign req_ready = (settle_ff == '0)
                   && ((state_ff == ST_IDLE) || ((state_ff == ST_ADD) && !emit_go));
   assign accept    = req_ch.valid && req_ready;
   assign settle_in = cfg.discount_wr ? CW'(MAX_WINDOW)
                    : ((settle_ff != '0) ? settle_ff - 1'b1 : settle_ff);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      ws_in         = ws_ff;
      load          = 1'b0;
      ctrl.mul_en   = 1'b0;
      ctrl.shift_en = 1'b0;
      ctrl.reward   = rew_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
               cnt_in   = cnt_trunc;
            end
         end
         ST_MUL: begin
            ctrl.mul_en = 1'b1;
            state_in    = ST_ADD;
         end
         ST_ADD: begin
            ctrl.shift_en = 1'b1;
            cnt_in        = cnt_p1;
            if (emit_go) begin
               state_in = ST_EMIT;
            end else if (accept) begin
               state_in = ST_MUL;
               cnt_in   = cnt_trunc;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load   = 1'b1;
               cnt_in = cnt_m1;
               ws_in  = ws_next;
               if (last_w) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         ws_ff        <= '0;
         settle_ff    <= CW'(MAX_WINDOW);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         ws_ff     <= ws_in;
         settle_ff <= settle_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff  <= req_ch.step_action;
         rew_ff  <= req_ch.step_reward;
         done_ff <= req_ch.episode_end;
      end
      if (load) begin
         rsp_action_ff <= act_arr[emit_idx];
         rsp_return_ff <= ret_arr[emit_idx];
         rsp_done_ff   <= done_ff;
         rsp_slot_ff   <= ws_wide[SLOT_W-1:0];
         rsp_last_ff   <= last_w;
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_action  = rsp_action_ff;
   assign rsp_ch.out_return  = rsp_return_ff;
   assign rsp_ch.out_done    = rsp_done_ff;
   assign rsp_ch.slot        = rsp_slot_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   `NSR_ASSERT(a_accept_starts_mul, accept |=> (state_ff == ST_MUL), "accepted item did not start")
   `NSR_ASSERT(a_emit_has_entry, (state_ff == ST_EMIT) |-> (cnt_ff != '0), "emitting from empty window")
   `NSR_ASSERT(a_last_ends_run, (load && last_w) |=> (state_ff == ST_IDLE), "run did not end on last")

endmodule
